// File: rtl/core/distributed_dfs_node_controller_unit_defines.svh
// Assertion macros shared by the node controller RTL.
`ifndef DISTRIBUTED_DFS_NODE_CONTROLLER_UNIT_DEFINES_SVH
`define DISTRIBUTED_DFS_NODE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// When cond holds at a clock edge, prop must hold at the same edge.
`define DDFS_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ddfs assertion failed");

// When cond holds at a clock edge, prop must hold at the following edge.
`define DDFS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ddfs assertion failed");

`else

`define DDFS_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define DDFS_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: rtl/core/ddfs_pkg.sv
// Types and constants shared by the node controller modules.
package ddfs_pkg;

   localparam int unsigned NODE_W     = 8;
   localparam int unsigned CHOICE_W   = 16;
   localparam int unsigned MOD_BITS   = 4;
   localparam int unsigned MOD_CYCLES = CHOICE_W / MOD_BITS;
   localparam int unsigned MOD_CNT_W  = $clog2(MOD_CYCLES);

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_INIT     = 2'd1,
      OP_TRAVERSE = 2'd2,
      OP_RETURN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_TRAVERSE = 2'd0,
      ACT_RETURN   = 2'd1,
      ACT_END      = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOD,
      ST_PICK,
      ST_FINISH
   } state_type;

   // Broadcast control for the row of neighbor cells.
   typedef struct packed {
      logic [NODE_W-1:0] key;
      logic [NODE_W-1:0] load_data;
      logic              load_en;
   } cell_ctl_type;

endpackage

// File: rtl/core/ddfs_cell.sv
// One neighbor slot of the compacted list, with search and shift tokens.
module ddfs_cell
   import ddfs_pkg::*;
#(
   parameter int unsigned INDEX   = 0,
   parameter int unsigned COUNT_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [COUNT_W-1:0] count,
   input  logic               search_in,
   input  logic               shift_in,
   input  logic [NODE_W-1:0]  next_data,
   output logic               search_out,
   output logic               shift_out,
   output logic [NODE_W-1:0]  data,
   output logic               busy,
   output logic               found
);

   logic              search_ff, search_in_w;
   logic              shift_ff, shift_in_w;
   logic [NODE_W-1:0] data_ff, data_in;
   logic              in_range;
   logic              hit;

   assign in_range = COUNT_W'(INDEX) < count;
   assign hit      = search_ff && in_range && (data_ff == ctl.key);

   // A hit turns the search token into a shift token that closes the gap,
   // one slot per cycle, as it moves toward the end of the row.
   assign search_out = search_ff && in_range && !hit;
   assign shift_out  = hit || shift_ff;
   assign found      = hit;
   assign busy       = search_ff || shift_ff;
   assign data       = data_ff;

   assign search_in_w = search_in;
   assign shift_in_w  = shift_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load_en && (count == COUNT_W'(INDEX))) begin
         data_in = ctl.load_data;
      end else if (hit || shift_ff) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff <= 1'b0;
         shift_ff  <= 1'b0;
      end else begin
         search_ff <= search_in_w;
         shift_ff  <= shift_in_w;
      end
      data_ff <= data_in;
   end

endmodule

// File: rtl/core/ddfs_mod.sv
// Iterative remainder unit: choice modulo the neighbor count, four bits a cycle.
module ddfs_mod
   import ddfs_pkg::*;
#(
   parameter int unsigned COUNT_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CHOICE_W-1:0] dividend,
   input  logic [COUNT_W-1:0]  divisor,
   output logic                done,
   output logic [COUNT_W-1:0]  remainder
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] step_ff, step_in;
   logic [CHOICE_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   step_rem;

   // Restoring steps: the partial remainder stays below the divisor.
   always_comb begin
      logic [COUNT_W:0]   trial;
      logic [COUNT_W-1:0] part;
      part  = rem_ff;
      trial = '0;
      for (int b = 0; b < MOD_BITS; b++) begin
         trial = {part, quo_ff[CHOICE_W-1-b]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         part = trial[COUNT_W-1:0];
      end
      step_rem = part;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         quo_in  = quo_ff << MOD_BITS;
         rem_in  = step_rem;
         step_in = step_ff + MOD_CNT_W'(1);
         if (step_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/distributed_dfs_node_controller_unit.sv
// Top level of one depth-first traversal node: sequencer, cell row, remainder unit.
//
//   channel | direction | tdata                              | tuser       | tlast
//   req_    | in        | [7:0] from_node, [23:8] choice     | [1:0] op    | -
//   rsp_    | out       | [7:0] dest_node                    | [1:0] action| node_done
//
// An init on an unvisited node with neighbors runs the 4-step remainder unit,
// one cell read and the result hand-off. A traverse or return walks a token
// down the cell row, then, when a neighbor is to be picked, the same remainder
// and read steps before the hand-off.
// Reset is synchronous and clears the count, flags and handshake state.
// A result waits in the output register; the next item is taken meanwhile and
// holds at its hand-off until the output register is free.
`include "distributed_dfs_node_controller_unit_defines.svh"

module distributed_dfs_node_controller_unit
   import ddfs_pkg::*;
#(
   parameter int unsigned MAX_NEIGHBORS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] from_node, [23:8] choice
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] dest_node
   output logic [1:0]  rsp_tuser,   // [1:0] action
   output logic        rsp_tlast
);

   localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]       count_ff, count_in;
   logic                visited_ff, visited_in;
   logic                has_pred_ff, has_pred_in;
   logic [NODE_W-1:0]   pred_ff, pred_in;
   logic                term_ff, term_in;
   op_type              op_ff, op_in;
   logic [NODE_W-1:0]   from_ff, from_in;
   logic [CHOICE_W-1:0] choice_ff, choice_in;
   action_type          res_action_ff, res_action_in;
   logic [NODE_W-1:0]   res_dest_ff, res_dest_in;
   logic                res_done_ff, res_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          rsp_action_ff, rsp_action_in;
   logic [NODE_W-1:0]   rsp_dest_ff, rsp_dest_in;
   logic                rsp_done_ff, rsp_done_in;

   logic                accept;
   op_type              req_op;
   logic [NODE_W-1:0]   req_from;
   logic [CHOICE_W-1:0] req_choice;
   logic                rsp_free;
   logic                token_start;
   logic                any_busy;
   logic                any_found;
   logic                mod_start;
   logic                mod_done;
   logic [CW-1:0]       mod_rem;
   logic [CHOICE_W-1:0] mod_dividend;
   logic [NODE_W-1:0]   pick_data;
   cell_ctl_type        cell_ctl;

   logic                search_chain [0:MAX_NEIGHBORS];
   logic                shift_chain  [0:MAX_NEIGHBORS];
   logic [NODE_W-1:0]   data_chain   [0:MAX_NEIGHBORS];
   logic [MAX_NEIGHBORS-1:0] busy_vec;
   logic [MAX_NEIGHBORS-1:0] found_vec;

   assign req_op     = op_type'(req_tuser);
   assign req_from   = req_tdata[7:0];
   assign req_choice = req_tdata[23:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // ---------------- cell row ----------------
   assign search_chain[0]          = token_start;
   assign shift_chain[0]           = 1'b0;
   assign data_chain[MAX_NEIGHBORS] = '0;

   for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
      ddfs_cell #(
         .INDEX   (g),
         .COUNT_W (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .count      (count_ff),
         .search_in  (search_chain[g]),
         .shift_in   (shift_chain[g]),
         .next_data  (data_chain[g+1]),
         .search_out (search_chain[g+1]),
         .shift_out  (shift_chain[g+1]),
         .data       (data_chain[g]),
         .busy       (busy_vec[g]),
         .found      (found_vec[g])
      );
   end

   // Tokens leaving the last cell come from its own flops, so they add no new busy time.
   assign any_busy  = (|busy_vec) || search_chain[MAX_NEIGHBORS] ||
                      shift_chain[MAX_NEIGHBORS];
   assign any_found = |found_vec;

   always_comb begin
      pick_data = '0;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         pick_data = pick_data | (data_chain[i] & {NODE_W{mod_rem == CW'(i)}});
      end
   end

   // ---------------- remainder unit ----------------
   assign mod_start    = (state_ff != ST_MOD) && (state_in == ST_MOD);
   assign mod_dividend = accept ? req_choice : choice_ff;

   ddfs_mod #(
      .COUNT_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !term_ff) begin
               unique case (req_op)
                  OP_LOAD: state_in = ST_IDLE;
                  OP_INIT: begin
                     if (visited_ff) begin
                        state_in = ST_IDLE;
                     end else if (count_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
                  OP_TRAVERSE, OP_RETURN: state_in = ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (!any_busy) begin
               unique case (op_ff)
                  OP_TRAVERSE: begin
                     if (visited_ff || (count_ff == '0)) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
                  OP_RETURN: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_MOD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      count_in      = count_ff;
      visited_in    = visited_ff;
      has_pred_in   = has_pred_ff;
      pred_in       = pred_ff;
      term_in       = term_ff;
      op_in         = op_ff;
      from_in       = from_ff;
      choice_in     = choice_ff;
      res_action_in = res_action_ff;
      res_dest_in   = res_dest_ff;
      res_done_in   = res_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_action_in = rsp_action_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_done_in   = rsp_done_ff;
      token_start   = 1'b0;
      cell_ctl.key       = from_ff;
      cell_ctl.load_data = req_from;
      cell_ctl.load_en   = 1'b0;

      if (any_found) begin
         count_in = count_ff - CW'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !term_ff) begin
               op_in     = req_op;
               from_in   = req_from;
               choice_in = req_choice;
               unique case (req_op)
                  OP_LOAD: begin
                     if (count_ff < CW'(MAX_NEIGHBORS)) begin
                        cell_ctl.load_en = 1'b1;
                        count_in         = count_ff + CW'(1);
                     end
                  end
                  OP_INIT: begin
                     if (!visited_ff) begin
                        visited_in  = 1'b1;
                        has_pred_in = 1'b0;
                        pred_in     = '0;
                        if (count_ff == '0) begin
                           res_action_in = ACT_END;
                           res_dest_in   = '0;
                           res_done_in   = 1'b1;
                        end
                     end
                  end
                  OP_TRAVERSE, OP_RETURN: token_start = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (!any_busy) begin
               unique case (op_ff)
                  OP_TRAVERSE: begin
                     if (visited_ff) begin
                        res_action_in = ACT_RETURN;
                        res_dest_in   = from_ff;
                        res_done_in   = 1'b0;
                     end else begin
                        visited_in  = 1'b1;
                        has_pred_in = 1'b1;
                        pred_in     = from_ff;
                        if (count_ff == '0) begin
                           res_action_in = ACT_RETURN;
                           res_dest_in   = from_ff;
                           res_done_in   = 1'b1;
                        end
                     end
                  end
                  OP_RETURN: begin
                     if (count_ff == '0) begin
                        res_done_in = 1'b1;
                        if (has_pred_ff) begin
                           res_action_in = ACT_RETURN;
                           res_dest_in   = pred_ff;
                        end else begin
                           res_action_in = ACT_END;
                           res_dest_in   = '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MOD: ;
         ST_PICK: begin
            res_action_in = ACT_TRAVERSE;
            res_dest_in   = pick_data;
            res_done_in   = 1'b0;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_action_in = res_action_ff;
               rsp_dest_in   = res_dest_ff;
               rsp_done_in   = res_done_ff;
               if (res_done_ff) begin
                  term_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         visited_ff   <= 1'b0;
         has_pred_ff  <= 1'b0;
         pred_ff      <= '0;
         term_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         visited_ff   <= visited_in;
         has_pred_ff  <= has_pred_in;
         pred_ff      <= pred_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      from_ff       <= from_in;
      choice_ff     <= choice_in;
      res_action_ff <= res_action_in;
      res_dest_ff   <= res_dest_in;
      res_done_ff   <= res_done_in;
      rsp_action_ff <= rsp_action_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dest_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_done_ff;

   // ---------------- assertions ----------------
   `DDFS_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MAX_NEIGHBORS))
   `DDFS_ASSERT_IMPLIES(a_single_token, clock, reset, 1'b1, $onehot0(busy_vec))
   `DDFS_ASSERT_IMPLIES(a_hit_in_scan, clock, reset, any_found, state_ff == ST_SCAN)
   `DDFS_ASSERT_IMPLIES(a_mod_in_state, clock, reset, mod_done, state_ff == ST_MOD)
   `DDFS_ASSERT_NEXT(a_term_sticky, clock, reset, term_ff, term_ff && (state_ff == ST_IDLE))

endmodule

// File: test/distributed_dfs_node_controller_unit_tb.sv
// Self-checking testbench for the depth-first traversal node controller.
`timescale 1ns / 1ps

module distributed_dfs_node_controller_unit_tb;
   import ddfs_pkg::*;

   localparam int NBR_SLOTS     = 8;
   localparam int RANDOM_ITEMS  = 680;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      op_type      op;
      logic [7:0]  src;
      logic [15:0] choice;
   } dfs_request_type;

   typedef struct {
      action_type action;
      logic [7:0] dest;
      logic       last;
   } node_msg_type;

   // How the node is brought into the traversal for this seed.
   typedef enum int {RUN_AS_ROOT, RUN_AS_CHILD, RUN_UNVISITED} run_plan_type;
   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BLOCKS} ready_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] from_node, [23:8] choice
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] dest_node
   logic [1:0]  rsp_tuser;        // [1:0] action
   logic        rsp_tlast;

   // Predicted node state.
   logic [7:0] nbr_ids [NBR_SLOTS];
   int         nbr_cnt    = 0;
   bit         visited    = 1'b0;
   bit         has_pred   = 1'b0;
   logic [7:0] pred_id    = 8'h00;
   bit         node_ended = 1'b0;

   dfs_request_type   pending_requests[$];
   node_msg_type      expected_messages[$];
   int                issued_items   = 0;
   int                accepted_items = 0;
   int                error_count    = 0;
   bit                req_taken      = 1'b0;
   int                burst_left     = 0;
   int                gap_left       = 0;
   logic [5:0]        stall_phase    = '0;
   ready_pattern_type stall_mode     = RDY_ALWAYS;

   distributed_dfs_node_controller_unit #(
      .MAX_NEIGHBORS(NBR_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (error_count < 40) $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   // Advances the predicted node by one accepted transaction.
   task automatic apply_dfs_message(input op_type op, input logic [7:0] src,
                                    input logic [15:0] choice);
      node_msg_type m;
      bit           emit;
      int           hit;
      int           i;
      emit = 1'b0;
      hit  = -1;
      if (node_ended) return;
      case (op)
         OP_LOAD: begin
            if (nbr_cnt < NBR_SLOTS) begin
               nbr_ids[nbr_cnt] = src;
               nbr_cnt++;
            end
         end
         OP_INIT: begin
            if (!visited) begin
               visited  = 1'b1;
               has_pred = 1'b0;
               pred_id  = 8'h00;
               emit     = 1'b1;
               if (nbr_cnt == 0) m = '{ACT_END, 8'h00, 1'b1};
               else m = '{ACT_TRAVERSE, nbr_ids[int'(choice) % nbr_cnt], 1'b0};
            end
         end
         default: begin
            // The sender is no longer a candidate: drop its first entry.
            for (i = 0; i < nbr_cnt; i++) begin
               if (hit < 0 && nbr_ids[i] == src) hit = i;
            end
            if (hit >= 0) begin
               for (i = hit; i < nbr_cnt - 1; i++) nbr_ids[i] = nbr_ids[i + 1];
               nbr_cnt--;
            end
            emit = 1'b1;
            if (op == OP_TRAVERSE && visited) begin
               m = '{ACT_RETURN, src, 1'b0};
            end else begin
               if (op == OP_TRAVERSE) begin
                  visited  = 1'b1;
                  pred_id  = src;
                  has_pred = 1'b1;
               end
               if (nbr_cnt > 0) m = '{ACT_TRAVERSE, nbr_ids[int'(choice) % nbr_cnt], 1'b0};
               else if (has_pred) m = '{ACT_RETURN, pred_id, 1'b1};
               else m = '{ACT_END, 8'h00, 1'b1};
            end
         end
      endcase
      if (emit) begin
         expected_messages.push_back(m);
         if (m.last) node_ended = 1'b1;
      end
   endtask

   // Queues one transaction and returns once the node has taken it, so the
   // predicted state is current when the next one is chosen.
   task automatic send_item(input op_type op, input logic [7:0] src,
                            input logic [15:0] choice);
      dfs_request_type it;
      it.op     = op;
      it.src    = src;
      it.choice = choice;
      pending_requests.push_back(it);
      issued_items++;
      wait (accepted_items == issued_items);
   endtask

   function automatic logic [15:0] rand_choice();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [7:0] rand_id();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] listed_id();
      return nbr_ids[$urandom_range(0, nbr_cnt - 1)];
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin : drive_requests
      dfs_request_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            it = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {it.choice, it.src};
            req_tuser  <= it.op;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result back-pressure: a new pattern is picked each time the 6-bit phase counter wraps.
   always @(negedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd0) stall_mode <= ready_pattern_type'($urandom_range(0, 3));
      case (stall_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_tready <= (stall_phase % 5 == 0);
         default:    rsp_tready <= stall_phase[5];
      endcase
   end

   always @(posedge clock) begin : observe
      node_msg_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_messages.size() == 0) begin
               report_mismatch($sformatf("unexpected result action=%0d dest=%0d done=%0b",
                                         rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = expected_messages.pop_front();
               if (rsp_tuser !== want.action)
                  report_mismatch($sformatf("action %0d, want %0d", rsp_tuser, want.action));
               if (rsp_tdata !== want.dest)
                  report_mismatch($sformatf("dest_node %0d, want %0d", rsp_tdata, want.dest));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("node_done %0b, want %0b", rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_dfs_message(op_type'(req_tuser), req_tdata[7:0], req_tdata[23:8]);
            accepted_items++;
         end
      end
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus
      run_plan_type plan;
      int           n;
      int           r;
      op_type       op;
      logic [7:0]   src;
      plan = run_plan_type'($urandom_range(0, 2));
      wait (!reset);

      // Fill the list past capacity, with a duplicate id; the last two drop.
      send_item(OP_LOAD, 8'h00, 16'h0000);
      send_item(OP_LOAD, 8'hFF, 16'hFFFF);
      send_item(OP_LOAD, 8'hA5, 16'h0000);
      send_item(OP_LOAD, 8'h5A, 16'hFFFF);
      send_item(OP_LOAD, 8'h5A, 16'h0000);
      send_item(OP_LOAD, 8'h01, 16'hFFFF);
      send_item(OP_LOAD, 8'h80, 16'h0000);
      send_item(OP_LOAD, 8'h7F, 16'hFFFF);
      send_item(OP_LOAD, 8'h33, 16'h0000);
      send_item(OP_LOAD, 8'hCC, 16'hFFFF);
      // Returns before any visit: unknown sender, duplicate, last entry.
      send_item(OP_RETURN, 8'h42, 16'hFFFF);
      send_item(OP_RETURN, 8'h5A, 16'h0000);
      send_item(OP_RETURN, 8'h7F, 16'h8000);
      send_item(OP_LOAD, 8'hE7, 16'h1234);

      case (plan)
         RUN_AS_ROOT: begin
            send_item(OP_INIT, 8'h00, 16'hFFFF);
            send_item(OP_INIT, 8'hFF, 16'h0000);
            send_item(OP_TRAVERSE, 8'h10, 16'h00FF);
            send_item(OP_TRAVERSE, 8'h00, 16'hFF00);
         end
         RUN_AS_CHILD: begin
            send_item(OP_TRAVERSE, 8'hFF, 16'h1234);
            send_item(OP_INIT, 8'h00, 16'hFFFF);
            send_item(OP_TRAVERSE, 8'hC3, 16'h0000);
            send_item(OP_RETURN, 8'h01, 16'hFFFF);
         end
         default: begin
            send_item(OP_RETURN, 8'h00, 16'hFFFE);
            send_item(OP_RETURN, 8'h99, 16'h0001);
         end
      endcase

      // Keep the node alive: the list never empties on a return until the end.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (nbr_cnt == 0 || r < 20) begin
            op  = OP_LOAD;
            src = (nbr_cnt > 0 && $urandom_range(0, 3) == 0) ? listed_id() : rand_id();
         end else if (r < 25 && plan != RUN_UNVISITED) begin
            op  = OP_INIT;
            src = rand_id();
         end else if (r < 60 && plan != RUN_UNVISITED) begin
            op  = OP_TRAVERSE;
            src = ($urandom_range(0, 1) != 0) ? listed_id() : rand_id();
         end else begin
            op  = OP_RETURN;
            src = (nbr_cnt > 1 && $urandom_range(0, 1) != 0) ? listed_id() : rand_id();
            if (nbr_cnt == 1 && src == nbr_ids[0]) src = ~src;
         end
         send_item(op, src, rand_choice());
      end

      // Return from every remaining neighbor until the node terminates.
      while (!node_ended)
         send_item(OP_RETURN, (nbr_cnt > 0) ? listed_id() : rand_id(), rand_choice());
      // Anything after termination must be ignored.
      repeat (6) send_item(op_type'($urandom_range(0, 3)), rand_id(), rand_choice());

      while (expected_messages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("distributed_dfs_node_controller_unit regression: pass");
      end else begin
         $display("distributed_dfs_node_controller_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("distributed_dfs_node_controller_unit regression: fail");
      $finish;
   end

endmodule
